### rtl/tdf_pkg.sv
// shared constants, types and command/status structs of the trial division factorizer
// used by tdf_datapath, tdf_controller and trial_division_factorizer_core; no dependencies
package tdf_pkg;

  localparam int VALUE_WIDTH = 32;
  // largest odd divisor tried stays at or just above the square root of the value
  localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 1;
  // running square of the divisor, with headroom for one step past the value
  localparam int SQ_WIDTH    = VALUE_WIDTH + 2;

  // divider retires this many quotient bits per cycle
  localparam int STEP_BITS   = 4;
  localparam int DIV_ITERS   = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int DVD_WIDTH   = DIV_ITERS * STEP_BITS;
  localparam int ITER_WIDTH  = $clog2(DIV_ITERS);

  localparam int MAX_RESULTS = 31;
  localparam int CNT_WIDTH   = $clog2(MAX_RESULTS + 1);

  localparam int FACTOR_TWO    = 2;
  localparam int FIRST_DIVISOR = 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_TWOS,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_TEST,
    S_FINAL
  } state_t;

  typedef enum logic [1:0] {
    SRC_EMPTY,
    SRC_TWO,
    SRC_DIV,
    SRC_REM
  } src_t;

  typedef struct packed {
    logic load_in;
    logic halve;
    logic init_div;
    logic start_div;
    logic take_quot;
    logic next_div;
    logic emit;
    src_t src;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic lt_two;
    logic odd;
    logic half_one;
    logic sq_le;
    logic gt_two;
    logic div_busy;
    logic rem_zero;
    logic quot_one;
    logic out_free;
    logic cap;
  } sts_t;

endpackage

### rtl/trial_division_factorizer_core.sv
// top level of the trial division factorizer: controller plus datapath
// depends on tdf_pkg, tdf_controller and tdf_datapath
//
// takes one unsigned value per input transaction and returns its prime factors in
// ascending order, one output transaction per factor with repeats, the final one
// flagged by last; an input of 0 or 1 returns a single transaction with factor 0,
// empty_res and last set. one value is factored at a time: in_stall stays high from
// the accepted transaction until its final factor has been loaded into the output
// register. the time per value is set by the trial loop: each odd divisor takes a
// square check, a divider start, the run of the 4-bit-per-cycle divider plus a check
// that it is done, and a remainder test, and each factor found costs another
// division. the work grows with the square root of the value when its largest factor
// is big; even parts cost one halving step per factor of two. the output register
// holds a finished factor while work continues, and the search only waits on
// out_stall when a new factor is ready to go out
module trial_division_factorizer_core (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic [tdf_pkg::VALUE_WIDTH-1:0]  value,
  input  logic                             in_valid,
  output logic                             in_stall,
  // output channel
  output logic [tdf_pkg::VALUE_WIDTH-1:0]  factor,
  output logic                             last,
  output logic                             empty_res,
  output logic                             out_valid,
  input  logic                             out_stall
);

  // command and status between the controller and the datapath
  tdf_pkg::cmd_t cmd;
  tdf_pkg::sts_t sts;

  // sequencing: strips factors of two, then walks odd divisors while d^2 <= remaining
  tdf_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // value, divisor, running square, iterative divider and output register
  tdf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .factor    (factor),
    .last      (last),
    .empty_res (empty_res),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

### rtl/tdf_datapath.sv
// datapath: remaining value, trial divisor and its square, radix-16 divider, output register
// depends on tdf_pkg; driven by tdf_controller through tdf_pkg::cmd_t
module tdf_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  tdf_pkg::cmd_t                    cmd,
  output tdf_pkg::sts_t                    sts,
  input  logic [tdf_pkg::VALUE_WIDTH-1:0]  value,
  output logic [tdf_pkg::VALUE_WIDTH-1:0]  factor,
  output logic                             last,
  output logic                             empty_res,
  output logic                             out_valid,
  input  logic                             out_stall
);

  localparam logic [tdf_pkg::CNT_WIDTH-1:0] CAP_COUNT =
    tdf_pkg::CNT_WIDTH'(tdf_pkg::MAX_RESULTS - 1);

  logic [tdf_pkg::VALUE_WIDTH-1:0] remaining;
  logic [tdf_pkg::DIV_WIDTH-1:0]   divisor;
  logic [tdf_pkg::SQ_WIDTH-1:0]    square;
  logic [tdf_pkg::DVD_WIDTH-1:0]   dvd;
  logic [tdf_pkg::DIV_WIDTH-1:0]   prem;
  logic [tdf_pkg::ITER_WIDTH-1:0]  iter;
  logic                            div_run;
  logic [tdf_pkg::CNT_WIDTH-1:0]   count;

  logic [tdf_pkg::DVD_WIDTH-1:0]   dvd_next;
  logic [tdf_pkg::DIV_WIDTH-1:0]   prem_next;
  logic [tdf_pkg::DIV_WIDTH:0]     trial;
  logic [tdf_pkg::VALUE_WIDTH-1:0] factor_next;

  // restoring division, STEP_BITS quotient bits per cycle; quotient shifts into dvd
  always_comb begin
    dvd_next  = dvd;
    prem_next = prem;
    trial     = '0;
    for (int s = 0; s < tdf_pkg::STEP_BITS; s++) begin
      trial    = {prem_next, dvd_next[tdf_pkg::DVD_WIDTH-1]};
      dvd_next = {dvd_next[tdf_pkg::DVD_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial       = trial - {1'b0, divisor};
        dvd_next[0] = 1'b1;
      end
      prem_next = trial[tdf_pkg::DIV_WIDTH-1:0];
    end
  end

  always_comb begin
    case (cmd.src)
      tdf_pkg::SRC_TWO: factor_next = tdf_pkg::VALUE_WIDTH'(tdf_pkg::FACTOR_TWO);
      tdf_pkg::SRC_DIV: factor_next = tdf_pkg::VALUE_WIDTH'(divisor);
      tdf_pkg::SRC_REM: factor_next = remaining;
      default:          factor_next = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      div_run   <= 1'b0;
      iter      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start_div) begin
        div_run <= 1'b1;
        iter    <= tdf_pkg::ITER_WIDTH'(tdf_pkg::DIV_ITERS - 1);
      end else if (div_run) begin
        iter <= iter - 1'b1;
        if (iter == '0) begin
          div_run <= 1'b0;
        end
      end
      if (cmd.load_in) begin
        count <= '0;
      end else if (cmd.emit) begin
        count <= count + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      remaining <= value;
    end else if (cmd.halve) begin
      remaining <= remaining >> 1;
    end else if (cmd.take_quot) begin
      remaining <= dvd[tdf_pkg::VALUE_WIDTH-1:0];
    end
    if (cmd.init_div) begin
      divisor <= tdf_pkg::DIV_WIDTH'(tdf_pkg::FIRST_DIVISOR);
      square  <= tdf_pkg::SQ_WIDTH'(tdf_pkg::FIRST_DIVISOR * tdf_pkg::FIRST_DIVISOR);
    end else if (cmd.next_div) begin
      // (d + 2)^2 = d^2 + 4d + 4
      divisor <= divisor + tdf_pkg::DIV_WIDTH'(2);
      square  <= square + tdf_pkg::SQ_WIDTH'({divisor, 2'b00}) + tdf_pkg::SQ_WIDTH'(4);
    end
    if (cmd.start_div) begin
      dvd  <= tdf_pkg::DVD_WIDTH'(remaining);
      prem <= '0;
    end else if (div_run) begin
      dvd  <= dvd_next;
      prem <= prem_next;
    end
    if (cmd.emit) begin
      factor    <= factor_next;
      last      <= cmd.last;
      empty_res <= (cmd.src == tdf_pkg::SRC_EMPTY);
    end
  end

  assign sts.lt_two   = remaining < tdf_pkg::VALUE_WIDTH'(2);
  assign sts.odd      = remaining[0];
  assign sts.half_one = remaining[tdf_pkg::VALUE_WIDTH-1:1] == (tdf_pkg::VALUE_WIDTH-1)'(1);
  assign sts.sq_le    = square <= {2'b00, remaining};
  assign sts.gt_two   = remaining > tdf_pkg::VALUE_WIDTH'(2);
  assign sts.div_busy = div_run;
  assign sts.rem_zero = prem == '0;
  assign sts.quot_one = dvd == tdf_pkg::DVD_WIDTH'(1);
  assign sts.out_free = !out_valid || !out_stall;
  assign sts.cap      = count == CAP_COUNT;

endmodule

### rtl/tdf_controller.sv
// controller state machine of the trial division factorizer
// depends on tdf_pkg; commands tdf_datapath through cmd_t, reads sts_t
module tdf_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tdf_pkg::sts_t sts,
  output tdf_pkg::cmd_t cmd
);

  tdf_pkg::state_t state;
  tdf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.src    = tdf_pkg::SRC_EMPTY;
    in_stall   = (state != tdf_pkg::S_IDLE);
    unique case (state)
      tdf_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = tdf_pkg::S_START;
        end
      end
      tdf_pkg::S_START: begin
        if (!sts.lt_two) begin
          state_next = tdf_pkg::S_TWOS;
        end else if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = tdf_pkg::SRC_EMPTY;
          cmd.last   = 1'b1;
          state_next = tdf_pkg::S_IDLE;
        end
      end
      tdf_pkg::S_TWOS: begin
        if (sts.odd) begin
          cmd.init_div = 1'b1;
          state_next   = tdf_pkg::S_CHECK;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = tdf_pkg::SRC_TWO;
          cmd.last  = sts.half_one || sts.cap;
          cmd.halve = 1'b1;
          if (cmd.last) begin
            state_next = tdf_pkg::S_IDLE;
          end
        end
      end
      tdf_pkg::S_CHECK: begin
        state_next = sts.sq_le ? tdf_pkg::S_DIV_GO : tdf_pkg::S_FINAL;
      end
      tdf_pkg::S_DIV_GO: begin
        cmd.start_div = 1'b1;
        state_next    = tdf_pkg::S_DIV_WAIT;
      end
      tdf_pkg::S_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_next = tdf_pkg::S_TEST;
        end
      end
      tdf_pkg::S_TEST: begin
        if (!sts.rem_zero) begin
          cmd.next_div = 1'b1;
          state_next   = tdf_pkg::S_CHECK;
        end else if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = tdf_pkg::SRC_DIV;
          cmd.last      = sts.quot_one || sts.cap;
          cmd.take_quot = 1'b1;
          state_next    = cmd.last ? tdf_pkg::S_IDLE : tdf_pkg::S_DIV_GO;
        end
      end
      tdf_pkg::S_FINAL: begin
        if (!sts.gt_two) begin
          state_next = tdf_pkg::S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = tdf_pkg::SRC_REM;
          cmd.last   = 1'b1;
          state_next = tdf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tdf_pkg::S_IDLE;
      end
    endcase
  end

endmodule
